// ===== hdl/ltc_pkg.sv =====
// Shared types and constants for the LRU tile tag cache.
// Used by ltc_cell and lru_tile_tag_cache_unit; no dependencies.
package ltc_pkg;

  localparam int ENTRIES_DEF = 128;
  localparam int ACTION_W    = 2;
  localparam int SLOT_W      = 16;
  localparam int REV_W       = 32;
  localparam int EPOCH_W     = 32;
  localparam int STAMP_W     = 64;
  localparam int ENTRY_W     = 7;

  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_EPOCH  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_id;
    logic [REV_W-1:0]    revision;
    logic [EPOCH_W-1:0]  epoch;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [ENTRY_W-1:0] entry;
    logic               evicted;
    logic [SLOT_W-1:0]  evicted_slot;
    logic               cleared;
  } out_t;

  // Flags of the scan packet that walks the cell row.
  typedef struct packed {
    logic go;
    logic found;
    logic rev_eq;
    logic free;
  } scan_flags_t;

  // Broadcast write data for the selected cell.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [REV_W-1:0]   rev;
    logic [STAMP_W-1:0] stamp;
  } ent_wr_t;

endpackage

// ===== hdl/lru_tile_tag_cache_unit.sv =====
// Top level of the LRU tile tag cache: control, use clock, epoch and the cell row.
// Depends on ltc_pkg and ltc_cell.
//
//   channel  ports                          direction  payload
//   in       in_valid, in_ready, in_data    input      ltc_pkg::in_t
//   out      out_valid, out_ready, out_data output     ltc_pkg::out_t
//
// A lookup or insert whose epoch matches sends a scan packet down the row of
// ENTRIES cells, one cell per cycle; its result is registered once the packet
// leaves the last cell and then moves to the output register. Other items skip
// the scan and register their result when they are taken.
// One item is in work at a time.
// rst_n clears all valid bits, the use clock and the epoch.
// A stalled output holds its item; the next input is taken while it waits.
module lru_tile_tag_cache_unit #(
  parameter int ENTRIES = ltc_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ltc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ltc_pkg::out_t out_data
);
  import ltc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  in_t                q_r;
  out_t               res_r, res_nxt;
  out_t               out_r;
  logic               out_valid_r, out_valid_nxt;
  logic [STAMP_W-1:0] use_clock_r, use_clock_nxt;
  logic [EPOCH_W-1:0] cur_epoch_r, cur_epoch_nxt;
  logic               start_r;

  logic               accept;
  logic               epoch_eq;
  logic               start;
  logic               clr;
  logic               scan_done;
  logic               wr_go;
  logic [IDX_W-1:0]   wr_idx;
  ent_wr_t            wr_data;

  scan_flags_t        fl        [ENTRIES+1];
  logic [IDX_W-1:0]   found_idx [ENTRIES+1];
  logic [IDX_W-1:0]   free_idx  [ENTRIES+1];
  logic [STAMP_W-1:0] min_stamp [ENTRIES+1];
  logic [IDX_W-1:0]   min_idx   [ENTRIES+1];
  logic [SLOT_W-1:0]  min_slot  [ENTRIES+1];

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign epoch_eq  = (in_data.epoch == cur_epoch_r);
  assign start     = accept && epoch_eq &&
                     ((in_data.action == ACT_LOOKUP) || (in_data.action == ACT_INSERT));
  assign clr       = accept && (in_data.action == ACT_EPOCH) && !epoch_eq;
  assign scan_done = fl[ENTRIES].go;

  // Inject the scan packet at the head of the row once the query is registered.
  assign fl[0]        = {start_r, 3'b000};
  assign found_idx[0] = '0;
  assign free_idx[0]  = '0;
  assign min_stamp[0] = '0;
  assign min_idx[0]   = '0;
  assign min_slot[0]  = '0;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    ltc_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .q_slot        (q_r.slot_id),
      .q_rev         (q_r.revision),
      .clr           (clr),
      .wr_go         (wr_go),
      .wr_idx        (wr_idx),
      .wr_data       (wr_data),
      .fl_in         (fl[k]),
      .found_idx_in  (found_idx[k]),
      .free_idx_in   (free_idx[k]),
      .min_stamp_in  (min_stamp[k]),
      .min_idx_in    (min_idx[k]),
      .min_slot_in   (min_slot[k]),
      .fl_out        (fl[k+1]),
      .found_idx_out (found_idx[k+1]),
      .free_idx_out  (free_idx[k+1]),
      .min_stamp_out (min_stamp[k+1]),
      .min_idx_out   (min_idx[k+1]),
      .min_slot_out  (min_slot[k+1])
    );
  end

  // Resolve the item once the packet leaves the last cell.
  always_comb begin
    wr_go         = 1'b0;
    wr_idx        = found_idx[ENTRIES];
    use_clock_nxt = use_clock_r + STAMP_W'(1);
    wr_data.slot  = q_r.slot_id;
    wr_data.rev   = q_r.revision;
    wr_data.stamp = use_clock_nxt;
    res_nxt       = '0;
    if (scan_done) begin
      if (q_r.action == ACT_LOOKUP) begin
        if (fl[ENTRIES].found && fl[ENTRIES].rev_eq) begin
          wr_go         = 1'b1;
          res_nxt.hit   = 1'b1;
          res_nxt.entry = ENTRY_W'(found_idx[ENTRIES]);
        end
      end else begin
        wr_go       = 1'b1;
        res_nxt.hit = 1'b1;
        priority if (fl[ENTRIES].found) begin
          wr_idx = found_idx[ENTRIES];
        end else if (fl[ENTRIES].free) begin
          wr_idx = free_idx[ENTRIES];
        end else begin
          wr_idx               = min_idx[ENTRIES];
          res_nxt.evicted      = 1'b1;
          res_nxt.evicted_slot = min_slot[ENTRIES];
        end
        res_nxt.entry = ENTRY_W'(wr_idx);
      end
    end else begin
      res_nxt.cleared = clr;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cur_epoch_nxt = clr ? in_data.epoch : cur_epoch_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end else if (accept) begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      use_clock_r <= '0;
      cur_epoch_r <= '0;
      start_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_epoch_r <= cur_epoch_nxt;
      start_r     <= start;
      if (wr_go) begin
        use_clock_r <= use_clock_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r <= in_data;
    end
    // Hold the result until the output register frees up.
    if (accept || scan_done) begin
      res_r <= res_nxt;
    end
    if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/ltc_cell.sv =====
// One cache entry plus one stage of the scan packet that walks the row.
// Depends on ltc_pkg.
module ltc_cell #(
  parameter int IDX_W = 7,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ltc_pkg::SLOT_W-1:0] q_slot,
  input  logic [ltc_pkg::REV_W-1:0]  q_rev,
  input  logic                       clr,
  input  logic                       wr_go,
  input  logic [IDX_W-1:0]           wr_idx,
  input  ltc_pkg::ent_wr_t           wr_data,
  input  ltc_pkg::scan_flags_t       fl_in,
  input  logic [IDX_W-1:0]           found_idx_in,
  input  logic [IDX_W-1:0]           free_idx_in,
  input  logic [ltc_pkg::STAMP_W-1:0] min_stamp_in,
  input  logic [IDX_W-1:0]           min_idx_in,
  input  logic [ltc_pkg::SLOT_W-1:0] min_slot_in,
  output ltc_pkg::scan_flags_t       fl_out,
  output logic [IDX_W-1:0]           found_idx_out,
  output logic [IDX_W-1:0]           free_idx_out,
  output logic [ltc_pkg::STAMP_W-1:0] min_stamp_out,
  output logic [IDX_W-1:0]           min_idx_out,
  output logic [ltc_pkg::SLOT_W-1:0] min_slot_out
);
  import ltc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic               valid_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [REV_W-1:0]   rev_r;
  logic [STAMP_W-1:0] stamp_r;

  scan_flags_t        fl_r, fl_nxt;
  logic [IDX_W-1:0]   found_idx_r, found_idx_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [STAMP_W-1:0] min_stamp_r, min_stamp_nxt;
  logic [IDX_W-1:0]   min_idx_r, min_idx_nxt;
  logic [SLOT_W-1:0]  min_slot_r, min_slot_nxt;

  logic               sel;
  logic               slot_hit;
  logic               take_min;

  assign sel      = wr_go && (wr_idx == MY_IDX);
  assign slot_hit = valid_r && (slot_r == q_slot);
  // First cell seeds the minimum; later cells replace only on a strictly smaller stamp.
  assign take_min = (IDX == 0) || (stamp_r < min_stamp_in);

  always_comb begin
    fl_nxt        = fl_in;
    found_idx_nxt = found_idx_in;
    free_idx_nxt  = free_idx_in;
    min_stamp_nxt = min_stamp_in;
    min_idx_nxt   = min_idx_in;
    min_slot_nxt  = min_slot_in;
    if (!fl_in.found && slot_hit) begin
      fl_nxt.found  = 1'b1;
      fl_nxt.rev_eq = (rev_r == q_rev);
      found_idx_nxt = MY_IDX;
    end
    if (!fl_in.free && !valid_r) begin
      fl_nxt.free  = 1'b1;
      free_idx_nxt = MY_IDX;
    end
    if (take_min) begin
      min_stamp_nxt = stamp_r;
      min_idx_nxt   = MY_IDX;
      min_slot_nxt  = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      slot_r  <= wr_data.slot;
      rev_r   <= wr_data.rev;
      stamp_r <= wr_data.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_r <= '0;
    end else begin
      fl_r <= fl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_idx_r <= found_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    min_stamp_r <= min_stamp_nxt;
    min_idx_r   <= min_idx_nxt;
    min_slot_r  <= min_slot_nxt;
  end

  assign fl_out        = fl_r;
  assign found_idx_out = found_idx_r;
  assign free_idx_out  = free_idx_r;
  assign min_stamp_out = min_stamp_r;
  assign min_idx_out   = min_idx_r;
  assign min_slot_out  = min_slot_r;

endmodule

// ===== tb/sv/lru_tile_tag_cache_unit_tb.sv =====
// Self-checking testbench for lru_tile_tag_cache_unit: a scoreboard class predicts each
// lookup, insert and epoch result; tasks and a receiver process drive both channels with random pacing.
// Depends on ltc_pkg and the RTL of the cache.
module lru_tile_tag_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ltc_pkg::*;

  localparam int NUM_ENT      = ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD    = 1200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  class tag_cache_scoreboard;
    bit                 ent_valid [NUM_ENT];
    logic [SLOT_W-1:0]  ent_slot  [NUM_ENT];
    logic [REV_W-1:0]   ent_rev   [NUM_ENT];
    logic [STAMP_W-1:0] ent_stamp [NUM_ENT];
    logic [STAMP_W-1:0] use_clock;
    logic [EPOCH_W-1:0] epoch_now;
    out_t pending_results [$];
    int errors, n_checked, n_hits, n_evicts, n_clears;

    function new();
      foreach (ent_valid[i]) ent_valid[i] = 1'b0;
      use_clock = '0;
      epoch_now = '0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function int find_slot(logic [SLOT_W-1:0] slot);
      int idx;
      idx = -1;
      for (int i = NUM_ENT - 1; i >= 0; i--)
        if (ent_valid[i] && ent_slot[i] == slot) idx = i;
      return idx;
    endfunction

    function void touch(int idx);
      use_clock = use_clock + 1;
      ent_stamp[idx] = use_clock;
    endfunction

    // Work out the result of one accepted access and update the tag store.
    function void note_access(in_t item);
      out_t res;
      int idx;
      res = '0;
      idx = -1;
      case (item.action)
        ACT_LOOKUP: begin
          if (item.epoch == epoch_now) begin
            idx = find_slot(item.slot_id);
            if (idx >= 0 && ent_rev[idx] == item.revision) begin
              touch(idx);
              res.hit = 1'b1;
              res.entry = idx[ENTRY_W-1:0];
              n_hits++;
            end
          end
        end
        ACT_INSERT: begin
          if (item.epoch == epoch_now) begin
            idx = find_slot(item.slot_id);
            if (idx < 0)
              for (int i = NUM_ENT - 1; i >= 0; i--)
                if (!ent_valid[i]) idx = i;
            // cache full: replace the oldest stamp, lowest index on a tie
            if (idx < 0) begin
              idx = 0;
              for (int i = 1; i < NUM_ENT; i++)
                if (ent_stamp[i] < ent_stamp[idx]) idx = i;
              res.evicted = 1'b1;
              res.evicted_slot = ent_slot[idx];
              n_evicts++;
            end
            ent_valid[idx] = 1'b1;
            ent_slot[idx] = item.slot_id;
            ent_rev[idx] = item.revision;
            touch(idx);
            res.hit = 1'b1;
            res.entry = idx[ENTRY_W-1:0];
          end
        end
        ACT_EPOCH: begin
          if (item.epoch != epoch_now) begin
            foreach (ent_valid[i]) ent_valid[i] = 1'b0;
            epoch_now = item.epoch;
            res.cleared = 1'b1;
            n_clears++;
          end
        end
        default: ;
      endcase
      pending_results.insert(pending_results.size(), res);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.hit !== want.hit)
        report($sformatf("hit got %b want %b", got.hit, want.hit));
      if (got.entry !== want.entry)
        report($sformatf("entry got %0d want %0d", got.entry, want.entry));
      if (got.evicted !== want.evicted)
        report($sformatf("evicted got %b want %b", got.evicted, want.evicted));
      if (got.evicted_slot !== want.evicted_slot)
        report($sformatf("evicted_slot got %h want %h", got.evicted_slot, want.evicted_slot));
      if (got.cleared !== want.cleared)
        report($sformatf("cleared got %b want %b", got.cleared, want.cleared));
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  tag_cache_scoreboard sb = new();

  logic [EPOCH_W-1:0] cur_epoch = '0;
  int n_sent, n_work, n_directed, burst_left, hold_request, n_long_holds;

  lru_tile_tag_cache_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic in_t mk(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] slot,
                             logic [REV_W-1:0] rev, logic [EPOCH_W-1:0] ep);
    in_t it;
    it.action = act;
    it.slot_id = slot;
    it.revision = rev;
    it.epoch = ep;
    return it;
  endfunction

  // Offer one item, hold it until accepted, then pace the next one in bursts.
  task automatic send_item(input in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(item);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 2 * NUM_ENT + 20)
                                        : $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_work(input in_t item);
    send_item(item);
    n_work++;
  endtask

  // Accesses the block drops: wrong epoch, unused action, repeated epoch.
  task automatic send_noise(input logic [SLOT_W-1:0] slot, input logic [REV_W-1:0] rev);
    case ($urandom_range(0, 3))
      0: send_item(mk(ACT_INSERT, slot, rev, cur_epoch ^ ($urandom | 32'h1)));
      1: send_item(mk(ACT_LOOKUP, slot, rev, cur_epoch ^ ($urandom | 32'h1)));
      2: send_item(mk(ACT_NONE, SLOT_W'($urandom), $urandom, $urandom));
      default: send_item(mk(ACT_EPOCH, SLOT_W'($urandom), $urandom, cur_epoch));
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One epoch worth of traffic: either a sweep that overfills the cache or a mixed run.
  task automatic run_block(input bit sweep);
    logic [SLOT_W-1:0] base;
    logic [REV_W-1:0]  pool_rev [256];
    int pool_n, k, r, len;
    base = SLOT_W'($urandom);
    foreach (pool_rev[i]) pool_rev[i] = $urandom;
    if ($urandom_range(0, 7) != 0) cur_epoch = $urandom;
    send_work(mk(ACT_EPOCH, SLOT_W'($urandom), $urandom, cur_epoch));
    if (sweep) begin
      pool_n = NUM_ENT + $urandom_range(8, 64);
      for (k = 0; k < pool_n && n_work < RANDOM_ITEMS; k++) begin
        pool_rev[k] = $urandom;
        send_work(mk(ACT_INSERT, SLOT_W'(base + k), pool_rev[k], cur_epoch));
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(0, k);
          send_work(mk(ACT_LOOKUP, SLOT_W'(base + r),
                       ($urandom_range(0, 7) == 0) ? $urandom : pool_rev[r], cur_epoch));
        end
        if ($urandom_range(0, 9) == 0) begin
          r = $urandom_range(0, k);
          pool_rev[r] = $urandom;
          send_work(mk(ACT_INSERT, SLOT_W'(base + r), pool_rev[r], cur_epoch));
        end
        if ($urandom_range(0, 11) == 0) send_noise(SLOT_W'(base + k), pool_rev[k]);
      end
    end else begin
      pool_n = $urandom_range(4, 48);
      len = $urandom_range(30, 120);
      repeat (len) begin
        if (n_work < RANDOM_ITEMS) begin
          r = $urandom_range(0, 99);
          k = $urandom_range(0, pool_n - 1);
          if (r < 40) begin
            if ($urandom_range(0, 2) == 0) pool_rev[k] = $urandom;
            send_work(mk(ACT_INSERT, SLOT_W'(base + k), pool_rev[k], cur_epoch));
          end else if (r < 85) begin
            send_work(mk(ACT_LOOKUP, SLOT_W'(base + k),
                         ($urandom_range(0, 5) == 0) ? $urandom : pool_rev[k], cur_epoch));
          end else if (r < 97) begin
            send_noise(SLOT_W'(base + k), pool_rev[k]);
          end else begin
            cur_epoch = $urandom;
            send_work(mk(ACT_EPOCH, SLOT_W'($urandom), $urandom, cur_epoch));
          end
        end
      end
    end
  endtask

  // Receiver: ready pattern changes in stretches; a long hold-off when asked.
  initial begin : receiver
    int mode, left, n;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        n_long_holds++;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 200);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (left % 5 != 0);
      endcase
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    in_t directed [$];
    int blk;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    directed = {directed, mk(ACT_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0000_0000)}; // empty miss
    directed = {directed, mk(ACT_INSERT, 16'h0000, 32'h0000_0000, 32'h0000_0000)};
    directed = {directed, mk(ACT_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0000_0000)};
    directed = {directed, mk(ACT_LOOKUP, 16'h0000, 32'h0000_0001, 32'h0000_0000)}; // stale rev
    directed = {directed, mk(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000)};
    directed = {directed, mk(ACT_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000)};
    directed = {directed, mk(ACT_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)}; // other epoch
    directed = {directed, mk(ACT_INSERT, 16'h1234, 32'h5555_AAAA, 32'h0000_0005)}; // dropped
    directed = {directed, mk(ACT_LOOKUP, 16'h1234, 32'h5555_AAAA, 32'h0000_0000)};
    directed = {directed, mk(ACT_INSERT, 16'h0000, 32'hA5A5_A5A5, 32'h0000_0000)}; // overwrite
    directed = {directed, mk(ACT_LOOKUP, 16'h0000, 32'h0000_0000, 32'h0000_0000)};
    directed = {directed, mk(ACT_LOOKUP, 16'h0000, 32'hA5A5_A5A5, 32'h0000_0000)};
    directed = {directed, mk(ACT_INSERT, 16'h0001, 32'h0000_0001, 32'h0000_0000)}; // next free
    directed = {directed, mk(ACT_NONE,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)};
    directed = {directed, mk(ACT_NONE,   16'h0000, 32'h0000_0000, 32'h0000_0000)};
    directed = {directed, mk(ACT_EPOCH,  16'h0000, 32'h0000_0000, 32'h0000_0000)}; // same epoch
    directed = {directed, mk(ACT_LOOKUP, 16'h0001, 32'h0000_0001, 32'h0000_0000)};
    directed = {directed, mk(ACT_EPOCH,  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)}; // clear
    directed = {directed, mk(ACT_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)};
    directed = {directed, mk(ACT_INSERT, 16'h8000, 32'h8000_0000, 32'hFFFF_FFFF)};
    directed = {directed, mk(ACT_LOOKUP, 16'h8000, 32'h8000_0000, 32'hFFFF_FFFF)};
    directed = {directed, mk(ACT_EPOCH,  16'h0000, 32'h0000_0000, 32'h0000_0000)};
    directed = {directed, mk(ACT_LOOKUP, 16'h8000, 32'h8000_0000, 32'h0000_0000)};
    foreach (directed[i]) send_item(directed[i]);
    n_directed = directed.size();
    cur_epoch = '0;
    wait_drained();

    // Second block runs under a long output stall so the input backs up.
    blk = 0;
    while (n_work < RANDOM_ITEMS) begin
      if (blk == 1) hold_request = LONG_HOLD;
      run_block(blk == 0 || $urandom_range(0, 2) == 0);
      if (blk == 0 || $urandom_range(0, 1) == 1) wait_drained();
      blk++;
    end

    wait_drained();
    repeat (2 * NUM_ENT + 8) @(posedge clk);

    $display("Covered %0d accesses (%0d directed) in %0d epoch blocks, %0d results checked",
             n_sent, n_directed, blk, sb.n_checked);
    $display("Lookup hits %0d, LRU evictions %0d, epoch clears %0d, long output stalls %0d",
             sb.n_hits, sb.n_evicts, sb.n_clears, n_long_holds);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ltc_pkg.sv
hdl/ltc_cell.sv
hdl/lru_tile_tag_cache_unit.sv
tb/sv/lru_tile_tag_cache_unit_tb.sv
